// ----- rtl/matrix_multiply_engine_defines.svh -----
// Assertion macros used by the matrix multiply engine checker.
`ifndef MATRIX_MULTIPLY_ENGINE_DEFINES_SVH
`define MATRIX_MULTIPLY_ENGINE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MME_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("matrix_multiply_engine: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("matrix_multiply_engine: next-cycle check failed");

`endif

// ----- rtl/mme_pkg.sv -----
// Shared types and constants of the matrix multiply engine.
package mme_pkg;

	localparam int KIND_W      = 2;
	localparam int ROW_W       = 4;
	localparam int COL_W       = 4;
	localparam int DATA_W      = 32;
	localparam int CFG_W       = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 32;

	localparam logic [KIND_W-1:0] KIND_WR_A  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WR_B  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

	localparam logic [CFG_W-1:0] SIZE_RESET = 5'd16;

	// Sequencer to multiply-accumulate unit.
	typedef struct packed {
		logic clear;
		logic load;
	} mme_mac_ctl_t;

endpackage

// ----- rtl/mme_ram.sv -----
// Single-port element store with registered read data.
module mme_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/mme_mac.sv -----
// Multiply-accumulate unit: registered 32x32 multiply, then 32-bit wrapping add.
module mme_mac (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mme_pkg::mme_mac_ctl_t       ctl,
	input  logic [mme_pkg::DATA_W-1:0]  a,
	input  logic [mme_pkg::DATA_W-1:0]  b,
	output logic                        busy,
	output logic [mme_pkg::DATA_W-1:0]  acc
);
	import mme_pkg::*;

	logic [DATA_W-1:0] prod_s2;
	logic              prod_valid_s2;
	logic [DATA_W-1:0] acc_q;

	// low half of the product is all that survives the wrap
	always_ff @(posedge clk) begin
		prod_s2 <= a * b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_valid_s2 <= 1'b0;
			acc_q         <= '0;
		end else begin
			prod_valid_s2 <= ctl.load;
			if (ctl.clear) begin
				acc_q <= '0;
			end else if (prod_valid_s2) begin
				acc_q <= acc_q + prod_s2;
			end
		end
	end

	assign busy = prod_valid_s2;
	assign acc  = acc_q;

endmodule

// ----- rtl/mme_ctrl.sv -----
// Sequencer: element writes, dot-product walk, and the result register.
module mme_ctrl #(
	parameter int MAX_DIM = 16,
	parameter int AW      = 8,
	parameter int CMP_W   = 7,
	parameter int IDX_W   = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [mme_pkg::KIND_W-1:0]   in_kind,
	input  logic [mme_pkg::ROW_W-1:0]    in_row,
	input  logic [mme_pkg::COL_W-1:0]    in_col,
	input  logic [mme_pkg::DATA_W-1:0]   in_value,
	input  logic [CMP_W-1:0]             nr,
	input  logic [CMP_W-1:0]             nk,
	input  logic [CMP_W-1:0]             nc,
	output logic                         we_a,
	output logic                         we_b,
	output logic [AW-1:0]                addr_a,
	output logic [AW-1:0]                addr_b,
	output logic [mme_pkg::DATA_W-1:0]   wdata,
	output mme_pkg::mme_mac_ctl_t        mac_ctl,
	input  logic                         mac_busy,
	input  logic [mme_pkg::DATA_W-1:0]   acc,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mme_pkg::DATA_W-1:0]   out_product,
	output logic                         out_oor
);
	import mme_pkg::*;

	localparam int MW = AW + 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]        state_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [IDX_W-1:0]  k_q;
	logic              oor_q;
	logic              rd_valid_s1;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_product_q;
	logic              out_oor_q;

	logic              accept;
	logic              row_in_a;
	logic              col_in_k;
	logic              row_in_k;
	logic              col_in_c;
	logic              q_oor;
	logic              k_last;
	logic              slot_free;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr_a;
	logic [AW-1:0]     rd_addr_b;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	assign row_in_a = CMP_W'(in_row) < nr;
	assign col_in_k = CMP_W'(in_col) < nk;
	assign row_in_k = CMP_W'(in_row) < nk;
	assign col_in_c = CMP_W'(in_col) < nc;
	assign q_oor    = !row_in_a || !col_in_c;

	// element (r, c) lives at r * MAX_DIM + c
	assign wr_addr   = AW'(MW'(in_row) * MW'(MAX_DIM) + MW'(in_col));
	assign rd_addr_a = AW'(MW'(row_q) * MW'(MAX_DIM) + MW'(k_q));
	assign rd_addr_b = AW'(MW'(k_q) * MW'(MAX_DIM) + MW'(col_q));

	assign we_a   = accept && (in_kind == KIND_WR_A) && row_in_a && col_in_k;
	assign we_b   = accept && (in_kind == KIND_WR_B) && row_in_k && col_in_c;
	assign addr_a = (state_q == ST_RUN) ? rd_addr_a : wr_addr;
	assign addr_b = (state_q == ST_RUN) ? rd_addr_b : wr_addr;
	assign wdata  = in_value;

	assign k_last    = (CMP_W'(k_q) == nk - CMP_W'(1));
	assign slot_free = !out_valid_q || out_ready;

	assign mac_ctl.clear = accept && (in_kind == KIND_QUERY);
	assign mac_ctl.load  = rd_valid_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= in_row;
			col_q <= in_col;
		end
		if (state_q == ST_FIN && slot_free) begin
			out_product_q <= oor_q ? '0 : acc;
			out_oor_q     <= oor_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			oor_q       <= 1'b0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == ST_RUN);
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (accept && in_kind == KIND_QUERY) begin
						oor_q <= q_oor;
						if (q_oor || nk == '0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					k_q <= k_q + IDX_W'(1);
					if (k_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// wait for the last pair to reach the accumulator
					if (!rd_valid_s1 && !mac_busy) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_product = out_product_q;
	assign out_oor     = out_oor_q;

endmodule

// ----- rtl/matrix_multiply_engine.sv -----
// Top level of the integer matrix multiply engine.
// Holds matrices A (rows_a x inner_dim) and B (inner_dim x cols_b) of signed 32-bit
// elements, each in a single-port memory of MAX_DIM*MAX_DIM words at row*MAX_DIM+col.
// Input words carry tuser = kind (0 write A, 1 write B, 2 query; 3 is dropped) and
// tdata = {value, col, row}. A write outside the configured sizes is dropped, as is
// kind 3; neither gives a result. A query gives one output word: the dot product of
// row of A and column of B, wrapped to 32 bits, with tuser (out_of_range) low; a query
// outside rows_a or cols_b gives zero with out_of_range high. Sizes above MAX_DIM act
// as MAX_DIM; an inner_dim of zero gives a product of zero. Elements read by a query
// must have been written first; the stores are not cleared at reset or on size change.
// A write leaves the input ready. A query in range occupies the block while one A/B
// element pair is read per cycle from the two memory ports and fed through the single
// shared multiply-accumulate unit, whose read, multiply and add stages then drain; an
// out-of-range query, or any query with an inner_dim of zero, skips this walk and goes
// straight to the result. The result sits in an output register, so a further write
// is taken while it waits; a following query may run but holds its own result until
// that register is free. Configuration is written through cfg_wr_en, cfg_index and
// cfg_wdata; the user must write it only while the block is idle, which the block
// itself does not enforce.
module matrix_multiply_engine #(
	parameter int MAX_DIM = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_wr_en,
	input  logic [mme_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mme_pkg::CFG_W-1:0]          cfg_wdata,
	// input stream
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [mme_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // row[3:0], col[7:4], value[39:8]
	input  logic [mme_pkg::KIND_W-1:0]         s_axis_tuser,  // kind[1:0]
	// result stream
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [mme_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // product[31:0]
	output logic                               m_axis_tuser   // out_of_range[0]
);
	import mme_pkg::*;

	localparam int DEPTH   = MAX_DIM * MAX_DIM;
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int SZ_W    = $clog2(MAX_DIM + 1);
	localparam int CMP_W   = (SZ_W > CFG_W) ? SZ_W : CFG_W;

	logic [CFG_W-1:0]  rows_a_q;
	logic [CFG_W-1:0]  inner_dim_q;
	logic [CFG_W-1:0]  cols_b_q;
	logic [CMP_W-1:0]  nr;
	logic [CMP_W-1:0]  nk;
	logic [CMP_W-1:0]  nc;

	logic              we_a;
	logic              we_b;
	logic [AW-1:0]     addr_a;
	logic [AW-1:0]     addr_b;
	logic [DATA_W-1:0] wdata;
	logic [DATA_W-1:0] rdata_a;
	logic [DATA_W-1:0] rdata_b;
	mme_mac_ctl_t      mac_ctl;
	logic              mac_busy;
	logic [DATA_W-1:0] acc;

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= SIZE_RESET;
			inner_dim_q <= SIZE_RESET;
			cols_b_q    <= SIZE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ROWS_A:    rows_a_q    <= cfg_wdata;
				REG_INNER_DIM: inner_dim_q <= cfg_wdata;
				REG_COLS_B:    cols_b_q    <= cfg_wdata;
				default: ;  // no register there: drop the write
			endcase
		end
	end

	// clamp each size to what the stores hold
	assign nr = (CMP_W'(rows_a_q) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : CMP_W'(rows_a_q);
	assign nk = (CMP_W'(inner_dim_q) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM)
		: CMP_W'(inner_dim_q);
	assign nc = (CMP_W'(cols_b_q) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : CMP_W'(cols_b_q);

	mme_ctrl #(
		.MAX_DIM (MAX_DIM),
		.AW      (AW),
		.CMP_W   (CMP_W),
		.IDX_W   (IDX_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_kind     (s_axis_tuser),
		.in_row      (s_axis_tdata[ROW_W-1:0]),
		.in_col      (s_axis_tdata[ROW_W+COL_W-1:ROW_W]),
		.in_value    (s_axis_tdata[ROW_W+COL_W+DATA_W-1:ROW_W+COL_W]),
		.nr          (nr),
		.nk          (nk),
		.nc          (nc),
		.we_a        (we_a),
		.we_b        (we_b),
		.addr_a      (addr_a),
		.addr_b      (addr_b),
		.wdata       (wdata),
		.mac_ctl     (mac_ctl),
		.mac_busy    (mac_busy),
		.acc         (acc),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_product (m_axis_tdata),
		.out_oor     (m_axis_tuser)
	);

	mme_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (DATA_W)
	) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.addr  (addr_a),
		.wdata (wdata),
		.rdata (rdata_a)
	);

	mme_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (DATA_W)
	) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.addr  (addr_b),
		.wdata (wdata),
		.rdata (rdata_b)
	);

	mme_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (rdata_a),
		.b      (rdata_b),
		.busy   (mac_busy),
		.acc    (acc)
	);

endmodule

// ----- rtl/mme_checker.sv -----
// Port-level checks of the matrix multiply engine, bound to the top level.
`include "matrix_multiply_engine_defines.svh"

module mme_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	input  logic [mme_pkg::KIND_W-1:0]       s_axis_tuser,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic [mme_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input  logic                             m_axis_tuser
);
	import mme_pkg::*;

	// a stalled result word holds
	`MME_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// an out-of-range result carries a zero product
	`MME_ASSERT_SAME(a_oor_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)

	// an accepted query takes the input out of ready while the sequencer works on it
	`MME_ASSERT_NEXT(a_query_busy, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_QUERY, !s_axis_tready)

	// writes and dropped kinds leave the input ready
	`MME_ASSERT_NEXT(a_write_ready, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser != KIND_QUERY, s_axis_tready)

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
